@@ design/rsat_pkg.sv @@
`default_nettype none

package rsat_pkg;

  localparam int SLOT_COUNT_DEFAULT = 16;
  localparam int SEQ_W = 16;
  localparam int ACTION_W = 2;
  localparam int SLOT_OUT_W = 4;

  // Input action codes
  localparam logic [ACTION_W-1:0] ACT_SENT      = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_HEARTBEAT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ACKNACK   = 2'd2;

  // Result kind codes
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_RESEND = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_Q,
    ST_MUL_R,
    ST_CLEAR,
    ST_SCAN,
    ST_FLUSH,
    ST_REPORT
  } state_t;

  // One operation on the slot occupancy map per cycle
  typedef struct packed {
    logic set;
    logic clr;
  } slot_op_t;

endpackage

`default_nettype wire

@@ design/reliable_sender_ack_tracker_unit.sv @@
`default_nettype none

// Acknowledgement tracker for the sender side of a reliable stream with
// 16-bit serial sequence numbers. A sent request marks slot (seq mod
// SLOT_COUNT) full; a heartbeat request returns one report (last acked + 1,
// last sent); an acknack frees the acknowledged slots, moves last acked to
// seq - 1 and returns one resend request per set mask bit whose slot is
// still full, lowest bit first, with last_of_run on the final one. One
// request is handled at a time and in_ready is high only when idle. The
// slot index comes from a shared 16x32 multiplier (reciprocal multiply,
// then multiply back and subtract). An acknack then walks the slot map: it
// clears one slot per cycle for each of the C (0..SLOT_COUNT) slots freed and
// then tests one mask position per cycle, SLOT_COUNT in all, unless the walk
// is stalled. A resend is held one step in a lookahead register so the
// last one can be tagged; the walk stalls only when that register must move
// into a still-occupied output register. The output register lets a new
// request in while the final result still waits to be taken.
module reliable_sender_ack_tracker_unit
  import rsat_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [ACTION_W-1:0]   action,
  input  wire logic [SEQ_W-1:0]      seq_num,
  input  wire logic [SEQ_W-1:0]      loss_mask,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       kind,
  output logic [SEQ_W-1:0]           first_unacked,
  output logic [SEQ_W-1:0]           last_unacked,
  output logic [SEQ_W-1:0]           resend_seq,
  output logic [SLOT_OUT_W-1:0]      resend_slot,
  output logic                       last_of_run
);

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int RECIP_W = 32;
  localparam int PROD_W = SEQ_W + RECIP_W;
  // ceil(2^32 / SLOT_COUNT): exact quotient for any 16-bit dividend
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << 32) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT));

  state_t state, state_next;

  // Request registers
  logic [ACTION_W-1:0] act_q;
  logic [SEQ_W-1:0]    seq_q;
  logic [SEQ_W-1:0]    nack_q;

  // Tracker state
  logic [SEQ_W-1:0]  last_acked;
  logic [SEQ_W-1:0]  newest_sent;
  logic [SLOT_W-1:0] start_slot;   // (last_acked + 1) mod SLOT_COUNT

  // Sequencer registers
  logic [SEQ_W-1:0]  q_reg;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  cnt;
  logic [SLOT_W-1:0] walk_slot;
  logic [SEQ_W-1:0]  walk_seq;     // number whose slot is walk_slot

  // Lookahead resend
  logic              cand_valid;
  logic [SEQ_W-1:0]  cand_seq;
  logic [SLOT_W-1:0] cand_slot;

  // Shared multiplier
  logic [SEQ_W-1:0]   mul_a;
  logic [RECIP_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [SEQ_W-1:0]   rem;
  logic [SLOT_W-1:0]  slot_calc;

  logic [SEQ_W-1:0]  fwd_dist;
  logic              ahead;
  logic [CNT_W-1:0]  clr_count;

  logic [SLOT_W-1:0] walk_inc;
  logic              nack_bit;
  logic              slot_full;
  logic              hit;
  logic              out_free;
  logic              scan_stall;
  logic              scan_adv;
  logic              scan_last;
  logic              clear_last;

  slot_op_t          slot_op;
  logic [SLOT_W-1:0] slot_idx;
  logic              cand_load;
  logic              load_resend;
  logic              load_report;

  rsat_slots #(
    .SLOT_COUNT(SLOT_COUNT),
    .SLOT_W(SLOT_W)
  ) u_slots (
    .clk (clk),
    .rst (rst),
    .op  (slot_op),
    .idx (slot_idx),
    .full(slot_full)
  );

  // Datapath helpers
  assign prod      = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign rem       = seq_q - prod[SEQ_W-1:0];
  assign slot_calc = rem[SLOT_W-1:0];

  // Serial distance from last_acked + 1 to the acknack number; half range
  // counts as not ahead
  assign fwd_dist = seq_q - (last_acked + 16'd1);
  assign ahead    = (fwd_dist != '0) && !fwd_dist[SEQ_W-1];
  always_comb begin
    if (!ahead) begin
      clr_count = '0;
    end else if (fwd_dist > SEQ_W'(SLOT_COUNT)) begin
      clr_count = CNT_W'(SLOT_COUNT);
    end else begin
      clr_count = fwd_dist[CNT_W-1:0];
    end
  end

  // Slot of the next number; a sequence wrap restarts at slot 0
  assign walk_inc   = (walk_seq == '1 || walk_slot == SLOT_W'(SLOT_COUNT - 1)) ?
                      '0 : walk_slot + 1'b1;
  assign nack_bit   = nack_q[4'(cnt)];
  assign hit        = nack_bit && slot_full;
  assign out_free   = !out_valid || out_ready;
  assign scan_stall = hit && cand_valid && !out_free;
  assign scan_adv   = (state == ST_SCAN) && !scan_stall;
  assign scan_last  = (cnt == CNT_W'(SLOT_COUNT - 1));
  assign clear_last = (cnt == count_q - 1'b1);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (action) inside
            ACT_SENT, ACT_ACKNACK: state_next = ST_MUL_Q;
            ACT_HEARTBEAT:         state_next = ST_REPORT;
            default:               state_next = ST_IDLE;
          endcase
        end
      end
      ST_MUL_Q: state_next = ST_MUL_R;
      ST_MUL_R: begin
        if (act_q == ACT_SENT) begin
          state_next = ST_IDLE;
        end else if (clr_count == '0) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (clear_last) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_adv && scan_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!cand_valid || out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready    = 1'b0;
    mul_a       = q_reg;
    mul_b       = RECIP_W'(SLOT_COUNT);
    slot_op     = '0;
    slot_idx    = walk_slot;
    cand_load   = 1'b0;
    load_resend = 1'b0;
    load_report = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_MUL_Q: begin
        mul_a = seq_q;
        mul_b = RECIP;
      end
      ST_MUL_R: begin
        slot_idx    = slot_calc;
        slot_op.set = (act_q == ACT_SENT);
      end
      ST_CLEAR: slot_op.clr = 1'b1;
      ST_SCAN: begin
        cand_load   = scan_adv && hit;
        load_resend = scan_adv && hit && cand_valid;
      end
      ST_FLUSH:  load_resend = cand_valid && out_free;
      ST_REPORT: load_report = out_free;
      default: ;
    endcase
  end

  // Sequencer and tracker registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      last_acked  <= '1;
      newest_sent <= '1;
      start_slot  <= '0;
      cand_valid  <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            act_q  <= action;
            seq_q  <= seq_num;
            nack_q <= loss_mask;
          end
        end
        ST_MUL_Q: q_reg <= prod[PROD_W-1:RECIP_W];
        ST_MUL_R: begin
          if (act_q == ACT_SENT) begin
            newest_sent <= seq_q;
          end else begin
            count_q    <= clr_count;
            cnt        <= '0;
            walk_slot  <= (clr_count == '0) ? slot_calc : start_slot;
            walk_seq   <= (clr_count == '0) ? seq_q : last_acked + 16'd1;
            start_slot <= slot_calc;
            last_acked <= seq_q - 16'd1;
          end
        end
        ST_CLEAR: begin
          if (clear_last) begin
            cnt       <= '0;
            walk_slot <= start_slot;
            walk_seq  <= seq_q;
          end else begin
            cnt       <= cnt + 1'b1;
            walk_slot <= walk_inc;
            walk_seq  <= walk_seq + 16'd1;
          end
        end
        ST_SCAN: begin
          if (scan_adv) begin
            cnt       <= cnt + 1'b1;
            walk_slot <= walk_inc;
            walk_seq  <= walk_seq + 16'd1;
          end
          if (cand_load) begin
            cand_valid <= 1'b1;
            cand_seq   <= seq_q + SEQ_W'(cnt);
            cand_slot  <= walk_slot;
          end
        end
        ST_FLUSH: begin
          if (load_resend) begin
            cand_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_resend) begin
      out_valid     <= 1'b1;
      kind          <= KIND_RESEND;
      first_unacked <= '0;
      last_unacked  <= '0;
      resend_seq    <= cand_seq;
      resend_slot   <= SLOT_OUT_W'(cand_slot);
      last_of_run   <= (state == ST_FLUSH);
    end else if (load_report) begin
      out_valid     <= 1'b1;
      kind          <= KIND_REPORT;
      first_unacked <= last_acked + 16'd1;
      last_unacked  <= newest_sent;
      resend_seq    <= '0;
      resend_slot   <= '0;
      last_of_run   <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ design/rsat_slots.sv @@
`default_nettype none

module rsat_slots
  import rsat_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT,
  parameter int SLOT_W = $clog2(SLOT_COUNT)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire slot_op_t          op,
  input  wire logic [SLOT_W-1:0] idx,
  output logic                   full
);

  logic [SLOT_COUNT-1:0] full_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_q <= '0;
    end else if (op.set) begin
      full_q[idx] <= 1'b1;
    end else if (op.clr) begin
      full_q[idx] <= 1'b0;
    end
  end

  assign full = full_q[idx];

endmodule

`default_nettype wire
